[rtl/binary_min_heap_queue_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the heap queue core
// Shared wrappers for concurrent checks on clk with synchronous rst_n.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication.
`define BMHQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// Sizes, codes and beat types shared by the heap queue core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int DEPTH     = 256;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int ENTRY_W   = KEY_W + PAY_W;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int IDX_W     = ADDR_W + 1;

  // Port field widths
  localparam int IN_KEY_W  = 32;
  localparam int IN_PAY_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 9;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [PAY_W-1:0]  pay_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    key_t key;
    pay_t pay;
  } entry_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t op;
    key_t    key;
    pay_t    pay;
  } req_t;

  typedef struct packed {
    key_t    key;
    pay_t    pay;
    status_t status;
    idx_t    count;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/bmhq_if.sv]
// ----------------------------------------------------------------------------
// bmhq_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_in_if import bmhq_pkg::*; ();
  logic                valid;
  logic                ready;
  opcode_t             opcode;
  logic [IN_KEY_W-1:0] item_key;
  logic [IN_PAY_W-1:0] item_payload;

  modport source (output valid, output opcode, output item_key, output item_payload,
                  input ready);
  modport sink   (input valid, input opcode, input item_key, input item_payload,
                  output ready);
endinterface

interface bmhq_out_if import bmhq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IN_KEY_W-1:0]  out_key;
  logic [IN_PAY_W-1:0]  out_payload;
  status_t              status;
  logic [OUT_CNT_W-1:0] entry_count;

  modport source (output valid, output out_key, output out_payload, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input out_key, input out_payload, input status,
                  input entry_count, output ready);
endinterface

`default_nettype wire

[rtl/bmhq_ram.sv]
// ----------------------------------------------------------------------------
// bmhq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/bmhq_engine.sv]
// ----------------------------------------------------------------------------
// bmhq_engine
// Sift sequencer: drives the heap RAM and one shared key comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "binary_min_heap_queue_core_defines.svh"

module bmhq_engine import bmhq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire req_t req,
  output logic      idle,
  output logic      done,
  output rsp_t      rsp,
  input  wire logic rsp_ready
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_UP_RD    = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_POP_LAST = 9'b000001000,
    S_POP_LOAD = 9'b000010000,
    S_DN_RD_L  = 9'b000100000,
    S_DN_RD_R  = 9'b001000000,
    S_DN_CMP   = 9'b010000000,
    S_FIN      = 9'b100000000
  } state_t;

  state_t  state_r, state_nxt;
  idx_t    cnt_r, cnt_nxt;
  addr_t   pos_r, pos_nxt;
  entry_t  elem_r, elem_nxt;        // entry being sifted, kept out of the RAM
  entry_t  best_r, best_nxt;        // smaller of left child and sifted entry
  logic    best_left_r, best_left_nxt;
  key_t    res_key_r, res_key_nxt;
  pay_t    res_pay_r, res_pay_nxt;
  status_t res_status_r, res_status_nxt;

  logic    we;
  addr_t   waddr, raddr;
  entry_t  wdata, rd_entry;
  logic [ENTRY_W-1:0] rdata;

  idx_t    l_idx, r_idx;
  addr_t   parent;
  key_t    cmp_a, cmp_b;
  logic    cmp_lt;

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_entry = entry_t'(rdata);
  assign l_idx    = {pos_r, 1'b1};
  assign r_idx    = l_idx + idx_t'(1);
  assign parent   = (pos_r - addr_t'(1)) >> 1;

  // Shared comparator
  always_comb begin
    case (state_r)
      S_UP_CMP:  begin cmp_a = elem_r.key;   cmp_b = rd_entry.key; end
      S_DN_RD_R: begin cmp_a = rd_entry.key; cmp_b = elem_r.key;   end
      S_DN_CMP:  begin cmp_a = rd_entry.key; cmp_b = best_r.key;   end
      default:   begin cmp_a = elem_r.key;   cmp_b = rd_entry.key; end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    elem_nxt       = elem_r;
    best_nxt       = best_r;
    best_left_nxt  = best_left_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    res_status_nxt = res_status_r;
    we             = 1'b0;
    waddr          = pos_r;
    wdata          = elem_r;
    raddr          = '0;
    done           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          res_key_nxt = '0;
          res_pay_nxt = '0;
          if (req.op == OP_PUSH) begin
            if (cnt_r == idx_t'(DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_FIN;
            end else begin
              res_status_nxt = ST_OK;
              elem_nxt       = '{key: req.key, pay: req.pay};
              pos_nxt        = cnt_r[ADDR_W-1:0];
              cnt_nxt        = cnt_r + idx_t'(1);
              state_nxt      = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              res_status_nxt = ST_OK;
              raddr          = '0;
              cnt_nxt        = cnt_r - idx_t'(1);
              state_nxt      = S_POP_LAST;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_FIN;
        end else begin
          raddr     = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cmp_lt) begin
          wdata     = rd_entry;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_POP_LAST: begin
        raddr       = cnt_r[ADDR_W-1:0];
        res_key_nxt = rd_entry.key;
        res_pay_nxt = rd_entry.pay;
        state_nxt   = S_POP_LOAD;
      end
      S_POP_LOAD: begin
        elem_nxt  = rd_entry;
        pos_nxt   = '0;
        state_nxt = (cnt_r == '0) ? S_FIN : S_DN_RD_L;
      end
      S_DN_RD_L: begin
        if (l_idx >= cnt_r) begin
          we        = 1'b1;
          state_nxt = S_FIN;
        end else begin
          raddr     = l_idx[ADDR_W-1:0];
          state_nxt = S_DN_RD_R;
        end
      end
      S_DN_RD_R: begin
        raddr = r_idx[ADDR_W-1:0];
        if (cmp_lt) begin
          best_nxt      = rd_entry;
          best_left_nxt = 1'b1;
        end else begin
          best_nxt      = elem_r;
          best_left_nxt = 1'b0;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (r_idx < cnt_r && cmp_lt) begin
          wdata     = rd_entry;
          pos_nxt   = r_idx[ADDR_W-1:0];
          state_nxt = S_DN_RD_L;
        end else if (best_left_r) begin
          wdata     = best_r;
          pos_nxt   = l_idx[ADDR_W-1:0];
          state_nxt = S_DN_RD_L;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        done = 1'b1;
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    elem_r       <= elem_nxt;
    best_r       <= best_nxt;
    best_left_r  <= best_left_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    res_status_r <= res_status_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign rsp  = '{key: res_key_r, pay: res_pay_r, status: res_status_r, count: cnt_r};

  `BMHQ_ASSERT_NEXT(a_push_count, start && idle && req.op == OP_PUSH && cnt_r != idx_t'(DEPTH), cnt_r == $past(cnt_r) + idx_t'(1), "accepted push did not advance the count")
  `BMHQ_ASSERT_IMPL(a_write_live, we, idx_t'(waddr) < cnt_r, "heap write outside the held entries")
  `BMHQ_ASSERT_IMPL(a_err_zero, done && rsp.status != ST_OK, rsp.key == '0 && rsp.pay == '0, "error result carries a non-zero entry")

endmodule

`default_nettype wire

[rtl/binary_min_heap_queue_core.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Min-heap priority queue with push/pop beats and one result beat per op.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries one operation per beat: opcode (push or pop), item_key and
//          item_payload. Keys compare unsigned; smaller keys leave first.
//   out_if returns exactly one result beat per operation: the popped key and
//          payload (zero for a push or an error), a status code (ok, pop on
//          empty, push on full) and the entry count after the operation.
// Timing:
//   One operation is worked at a time; in_if.ready is low from acceptance
//   until the result is handed to the output register. A push climbs from
//   its new slot towards the root; a pop moves the last entry to the root
//   and sifts it down; an error goes straight to its result.
// Reset:
//   rst_n (synchronous) empties the queue; RAM contents are not cleared, as
//   only data from slots that a push has written is ever used.
// Back-pressure:
//   the result beat holds in the output register until out_if.ready; the
//   next operation may be accepted meanwhile, but its result waits in the
//   engine, with in_if.ready low, until the register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "binary_min_heap_queue_core_defines.svh"

module binary_min_heap_queue_core import bmhq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bmhq_in_if.sink     in_if,
  bmhq_out_if.source  out_if
);

  logic eng_idle;
  logic eng_done;
  logic rsp_ready;
  req_t req;
  rsp_t rsp;

  logic                 out_valid_r;
  logic [IN_KEY_W-1:0]  out_key_r;
  logic [IN_PAY_W-1:0]  out_pay_r;
  status_t              out_status_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  // Drop key and payload bits above the stored widths
  assign req = '{op:  in_if.opcode,
                 key: in_if.item_key[KEY_W-1:0],
                 pay: in_if.item_payload[PAY_W-1:0]};

  assign in_if.ready = eng_idle;

  // Let the engine finish whenever the output register is free or draining
  assign rsp_ready = !out_valid_r || out_if.ready;

  bmhq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_if.valid),
    .req       (req),
    .idle      (eng_idle),
    .done      (eng_done),
    .rsp       (rsp),
    .rsp_ready (rsp_ready)
  );

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done && rsp_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done && rsp_ready) begin
      out_key_r    <= IN_KEY_W'(rsp.key);
      out_pay_r    <= IN_PAY_W'(rsp.pay);
      out_status_r <= rsp.status;
      out_count_r  <= OUT_CNT_W'(rsp.count);
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_key     = out_key_r;
  assign out_if.out_payload = out_pay_r;
  assign out_if.status      = out_status_r;
  assign out_if.entry_count = out_count_r;

  `BMHQ_ASSERT_NEXT(a_busy_after_accept, in_if.valid && in_if.ready, !in_if.ready, "engine took a second beat while busy")

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_min_heap_queue_core: pushes and pops go in
// over the operation channel, a heap predictor held here works out every
// result beat, and the monitor checks key, payload, status and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bmhq_pkg::*;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int LONG_HOLD_AT     = 700;  // beats accepted before the long stall
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 60;

  typedef struct {
    opcode_t op;
    key_t    key;
    pay_t    pay;
    bit      drain_first;  // hold this beat until every result is back
  } heap_op_t;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_BLOCKED
  } rx_mode_t;

  logic clk;
  logic rst_n;

  bmhq_in_if  in_if ();
  bmhq_out_if out_if ();

  binary_min_heap_queue_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Heap predictor: its own copy of the store and the entry count.
  // --------------------------------------------------------------------------
  entry_t heap_slot [DEPTH];
  int     held_entries;

  heap_op_t op_backlog [$];
  rsp_t     pending_results [$];

  int ops_accepted;
  int error_count;
  int cycle_count;
  bit beat_taken;

  function automatic void slot_swap(int a, int b);
    entry_t t;
    t            = heap_slot[a];
    heap_slot[a] = heap_slot[b];
    heap_slot[b] = t;
  endfunction

  // Apply one operation to the predicted heap and return the result beat.
  function automatic rsp_t heap_apply(opcode_t op, key_t key, pay_t pay);
    rsp_t r;
    int   pos;
    int   up;
    int   best;
    int   lc;
    int   rc;
    r        = '0;
    r.status = ST_OK;
    if (op == OP_PUSH) begin
      if (held_entries >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos                = held_entries;
        heap_slot[pos].key = key;
        heap_slot[pos].pay = pay;
        held_entries++;
        // Climb while strictly smaller than the parent; equal keys stay put.
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_slot[pos].key >= heap_slot[up].key) break;
          slot_swap(pos, up);
          pos = up;
        end
      end
    end else begin
      if (held_entries == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = heap_slot[0].key;
        r.pay = heap_slot[0].pay;
        held_entries--;
        if (held_entries > 0) begin
          heap_slot[0] = heap_slot[held_entries];
          pos = 0;
          // Descend towards the strictly smaller child; left wins a tie.
          forever begin
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            best = pos;
            if (lc < held_entries && heap_slot[lc].key < heap_slot[best].key) best = lc;
            if (rc < held_entries && heap_slot[rc].key < heap_slot[best].key) best = rc;
            if (best == pos) break;
            slot_swap(pos, best);
            pos = best;
          end
        end
      end
    end
    r.count = idx_t'(held_entries);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic queue_op(opcode_t op, key_t key, pay_t pay, bit drain_first);
    heap_op_t h;
    h.op          = op;
    h.key         = key;
    h.pay         = pay;
    h.drain_first = drain_first;
    op_backlog.push_back(h);
  endtask

  // A run of random operations; push_pct steers the heap towards full or
  // empty. Keys are drawn from a narrow range often, so that ties are common.
  task automatic queue_phase(int n, int push_pct);
    opcode_t op;
    key_t    key;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: key = $urandom;
        4, 5, 6, 7: key = $urandom_range(0, 15);
        8:          key = '0;
        default:    key = '1;
      endcase
      queue_op(op, key, $urandom, i == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer beats at the falling edge, in bursts with random gaps.
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  // Record acceptance and predict at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      pending_results.push_back(heap_apply(in_if.opcode, in_if.item_key, in_if.item_payload));
      beat_taken = 1'b1;
      ops_accepted++;
    end
  end

  always @(negedge clk) begin
    heap_op_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || beat_taken) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (op_backlog.size() == 0 ||
                   (op_backlog[0].drain_first && pending_results.size() != 0)) begin
        // Nothing left, or hold until the block has handed back every result.
        in_if.valid <= 1'b0;
      end else begin
        nxt = op_backlog.pop_front();
        in_if.valid        <= 1'b1;
        in_if.opcode       <= nxt.op;
        in_if.item_key     <= nxt.key;
        in_if.item_payload <= nxt.pay;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          case ($urandom_range(0, 19))
            0:       gap_left = $urandom_range(20, 40);
            1, 2, 3, 4, 5, 6, 7, 8, 9:
                     gap_left = $urandom_range(1, 6);
            default: gap_left = 0;
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready pattern of its own, plus one long hold-off that backs the
  // block up until it stalls its input.
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode;
  int       rx_left;
  int       long_hold_left;
  bit       long_hold_done;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      out_if.ready <= 1'b0;
    end else if (!long_hold_done && ops_accepted >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else begin
      if (rx_left > 0) begin
        rx_left--;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            rx_mode = RX_OPEN;
            rx_left = $urandom_range(5, 60);
          end
          1: begin
            rx_mode = RX_RANDOM;
            rx_left = $urandom_range(5, 40);
          end
          default: begin
            rx_mode = RX_BLOCKED;
            rx_left = $urandom_range(0, 8);
          end
        endcase
      end
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
        default:   out_if.ready <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no operation outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_key",     want.key,    out_if.out_key);
        check_field("out_payload", want.pay,    out_if.out_payload);
        check_field("status",      32'(want.status), 32'(out_if.status));
        check_field("entry_count", 32'(want.count),  32'(out_if.entry_count));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge.
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.opcode        = OP_PUSH;
    in_if.item_key      = '0;
    in_if.item_payload  = '0;
    out_if.ready        = 1'b0;
    held_entries        = 0;
    ops_accepted        = 0;
    error_count         = 0;
    cycle_count         = 0;
    beat_taken          = 1'b0;
    burst_left          = 0;
    gap_left            = 0;
    rx_mode             = RX_OPEN;
    rx_left             = 0;
    long_hold_left      = 0;
    long_hold_done      = 1'b0;

    // Directed: pop on empty, key and payload extremes, equal keys that must
    // leave in a fixed order, and a pop that empties the heap again.
    queue_op(OP_POP,  '0,            '0,            1'b1);
    queue_op(OP_PUSH, '1,            '0,            1'b0);
    queue_op(OP_PUSH, '0,            '1,            1'b0);
    queue_op(OP_PUSH, 32'd5,         32'h0000_000A, 1'b0);
    queue_op(OP_PUSH, 32'd5,         32'h0000_000B, 1'b0);
    queue_op(OP_PUSH, 32'd5,         32'h0000_000C, 1'b0);
    queue_op(OP_PUSH, '0,            32'h0000_0001, 1'b0);
    queue_op(OP_PUSH, 32'd5,         32'h0000_000D, 1'b0);
    for (int i = 0; i < 7; i++) queue_op(OP_POP, $urandom, $urandom, 1'b0);
    queue_op(OP_POP,  '0,            '0,            1'b0);
    queue_op(OP_PUSH, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0);
    queue_op(OP_PUSH, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0);
    queue_op(OP_POP,  '0,            '0,            1'b0);
    queue_op(OP_POP,  '0,            '0,            1'b0);

    // Random: mixed, fill past full, drain past empty, then mixed, fill past full and drain a long way.
    queue_phase(250, 50);
    queue_phase(330, 95);
    queue_phase(330, 8);
    queue_phase(200, 55);
    queue_phase(330, 90);
    queue_phase(300, 15);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to go in and every result to come back.
    while (op_backlog.size() != 0 || in_if.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
